// File: hdl/dfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_pkg: shared types, constants and font for the digit framebuffer renderer
// Holds the operation codes, the queue entry layout and the 5x7 digit font.
// ----------------------------------------------------------------------------
package dfr_pkg;

    localparam int DEF_WIDTH  = 128;
    localparam int DEF_HEIGHT = 64;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_PIXEL = 2'd1,
        OP_DRAW  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // one classified command handed from front to back
    typedef struct packed {
        op_t          op;
        logic [8:0]   px;
        logic [8:0]   py;
        logic         on;
        logic [31:0]  value;
        logic [3:0]   scale;
        logic [9:0]   index;
    } cmd_t;

    // column c (0..4) of digit d (0..9), LSB is top row
    function automatic logic [6:0] font_col(input logic [3:0] d, input logic [2:0] c);
        logic [34:0] g;
        begin
            unique case (d)
                4'd0: g = {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
                4'd1: g = {7'h00, 7'h40, 7'h7F, 7'h42, 7'h00};
                4'd2: g = {7'h46, 7'h49, 7'h51, 7'h61, 7'h42};
                4'd3: g = {7'h31, 7'h4B, 7'h45, 7'h41, 7'h21};
                4'd4: g = {7'h10, 7'h7F, 7'h12, 7'h14, 7'h18};
                4'd5: g = {7'h39, 7'h45, 7'h45, 7'h45, 7'h27};
                4'd6: g = {7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C};
                4'd7: g = {7'h03, 7'h05, 7'h09, 7'h71, 7'h01};
                4'd8: g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
                4'd9: g = {7'h1E, 7'h29, 7'h49, 7'h49, 7'h06};
                default: g = '0;
            endcase
            unique case (c)
                3'd0: font_col = g[6:0];
                3'd1: font_col = g[13:7];
                3'd2: font_col = g[20:14];
                3'd3: font_col = g[27:21];
                3'd4: font_col = g[34:28];
                default: font_col = '0;
            endcase
        end
    endfunction

endpackage

// File: hdl/dfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_front: command intake
// Unpacks input words into commands and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module dfr_front import dfr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       in_cmd;
    logic       push, pop;

    always_comb begin
        in_cmd.op    = op_t'(s_tdata[1:0]);
        in_cmd.px    = s_tdata[10:2];
        in_cmd.py    = s_tdata[19:11];
        in_cmd.on    = s_tdata[20];
        in_cmd.value = s_tdata[52:21];
        in_cmd.scale = s_tdata[56:53];
        in_cmd.index = s_tdata[66:57];
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd0 |-> !pop) else $error("queue underflow");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("count slip");

endmodule

// File: hdl/dfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfr_back: command execution
// Owns the frame store; clears, plots, rasterizes digits and reads bytes.
// ----------------------------------------------------------------------------
module dfr_back import dfr_pkg::*; #(
    parameter int DISPLAY_WIDTH  = DEF_WIDTH,
    parameter int DISPLAY_HEIGHT = DEF_HEIGHT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_valid,
    output logic       q_ready,
    input  cmd_t       q_cmd,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);

    localparam int PAGES = (DISPLAY_HEIGHT + 7) / 8;
    localparam int BYTES = DISPLAY_WIDTH * PAGES;
    localparam int AW    = $clog2(BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_PIX_RD, S_PIX_WR, S_DIV, S_ORIGIN, S_FONT,
        S_GRD, S_GRR, S_GWR, S_READ, S_OUT
    } state_t;

    state_t        state_reg;
    logic [7:0]    mem [BYTES];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] addr_reg;
    logic [AW:0]   clr_reg;
    logic [7:0]    mask_reg;
    logic          on_reg;
    logic          rd_ok_reg;
    logic [7:0]    out_reg;
    logic          out_valid_reg;
    // number draw state
    logic [31:0]   val_reg;
    logic [3:0]    digs_reg [10];
    logic [3:0]    n_reg;
    logic [3:0]    scale_reg;
    logic [3:0]    di_reg;
    logic [2:0]    col_reg;
    logic [2:0]    row_reg;
    logic [3:0]    dx_reg, dy_reg;
    logic signed [12:0] oy_reg;
    logic signed [12:0] gx_reg, gy_reg;
    logic [6:0]    bits_reg;

    // divide by 10 via reciprocal multiply
    logic [63:0]   prod;
    logic [31:0]   quo;
    logic [3:0]    rem;
    assign prod = val_reg * 64'd3435973837;
    assign quo  = {3'd0, prod[63:35]};
    assign rem  = 4'(val_reg - quo * 32'd10);

    // origin math
    logic signed [12:0] tw, ox_num, oy_num, ox_val, oy_val;
    always_comb begin
        tw     = 13'(({9'd0, n_reg} * 13'd6 - 13'd1) * {9'd0, scale_reg});
        ox_num = 13'(DISPLAY_WIDTH) - tw;
        oy_num = 13'(DISPLAY_HEIGHT) - 13'({9'd0, scale_reg} * 13'd7);
        // truncate toward zero
        ox_val = ox_num[12] ? -((-ox_num) >>> 1) : (ox_num >>> 1);
        oy_val = oy_num[12] ? -((-oy_num) >>> 1) : (oy_num >>> 1);
    end

    // current plot coordinate, one rasterized pixel
    logic signed [12:0] cx, cy;
    logic               cin;
    logic [AW-1:0]      caddr;
    always_comb begin
        cx    = gx_reg + 13'({9'd0, dx_reg});
        cy    = gy_reg + 13'({9'd0, dy_reg});
        cin   = !cx[12] && !cy[12] && cx < 13'(DISPLAY_WIDTH) && cy < 13'(DISPLAY_HEIGHT);
        caddr = AW'(({3'd0, cy[12:3]} * 13'(DISPLAY_WIDTH)) + cx);
    end

    // pixel op address
    logic signed [9:0] spx, spy;
    logic              pin;
    logic [AW-1:0]     paddr;
    always_comb begin
        spx   = {q_cmd.px[8], q_cmd.px};
        spy   = {q_cmd.py[8], q_cmd.py};
        pin   = !spx[9] && !spy[9] && spx < 10'(DISPLAY_WIDTH) && spy < 10'(DISPLAY_HEIGHT);
        paddr = AW'(({7'd0, spy[8:3]} * 13'(DISPLAY_WIDTH)) + 13'(spx));
    end

    assign q_ready  = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    always_comb begin
        we = 1'b0; waddr = addr_reg; wdata = 8'd0;
        unique case (state_reg)
            S_CLEAR: begin we = 1'b1; waddr = clr_reg[AW-1:0]; end
            S_PIX_WR: begin
                we = 1'b1;
                wdata = on_reg ? (rdata_reg | mask_reg) : (rdata_reg & ~mask_reg);
            end
            // unlit or clipped pixels leave the store alone
            S_GWR: begin we = (mask_reg != 8'd0); wdata = rdata_reg | mask_reg; end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        unique case (q_cmd.op)
                            OP_CLEAR: begin clr_reg <= '0; state_reg <= S_CLEAR; end
                            OP_PIXEL: begin
                                addr_reg  <= paddr;
                                mask_reg  <= 8'(1) << spy[2:0];
                                on_reg    <= q_cmd.on;
                                state_reg <= pin ? S_PIX_RD : S_IDLE;
                            end
                            OP_DRAW: begin
                                val_reg   <= q_cmd.value;
                                scale_reg <= q_cmd.scale;
                                n_reg     <= 4'd0;
                                state_reg <= (q_cmd.scale == 4'd0) ? S_IDLE : S_DIV;
                            end
                            OP_READ: begin
                                addr_reg  <= AW'(q_cmd.index);
                                rd_ok_reg <= ({22'd0, q_cmd.index} < BYTES);
                                state_reg <= S_READ;
                            end
                            default: ;
                        endcase
                    end
                end
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(BYTES - 1)) state_reg <= S_IDLE;
                end
                S_PIX_RD: state_reg <= S_PIX_WR;
                S_PIX_WR: state_reg <= S_IDLE;
                S_DIV: begin
                    digs_reg[n_reg] <= rem;
                    n_reg   <= n_reg + 4'd1;
                    val_reg <= quo;
                    if (quo == 32'd0 || n_reg == 4'd9) state_reg <= S_ORIGIN;
                end
                S_ORIGIN: begin
                    oy_reg <= oy_val;
                    gx_reg <= ox_val; gy_reg <= oy_val;
                    di_reg <= 4'd0; col_reg <= 3'd0; row_reg <= 3'd0;
                    dx_reg <= 4'd0; dy_reg <= 4'd0;
                    state_reg <= S_FONT;
                end
                S_FONT: begin
                    // fetch column bits of the current digit (most significant first)
                    bits_reg <= font_col(digs_reg[n_reg - 4'd1 - di_reg], col_reg);
                    state_reg <= S_GRD;
                end
                S_GRD: begin
                    // address pixel (dx,dy) inside the cell of row_reg
                    addr_reg  <= caddr;
                    state_reg <= S_GRR;
                    if (bits_reg[row_reg] && cin) begin
                        mask_reg <= 8'(1) << cy[2:0];
                    end else begin
                        mask_reg <= 8'd0;
                    end
                end
                // wait for the store byte to land in rdata_reg
                S_GRR: state_reg <= S_GWR;
                S_GWR: begin
                    // step dy, dx, row, col, digit
                    state_reg <= S_GRD;
                    if (dy_reg != scale_reg - 4'd1) begin
                        dy_reg <= dy_reg + 4'd1;
                    end else begin
                        dy_reg <= 4'd0;
                        if (dx_reg != scale_reg - 4'd1) begin
                            dx_reg <= dx_reg + 4'd1;
                        end else begin
                            dx_reg <= 4'd0;
                            if (row_reg != 3'd6) begin
                                row_reg <= row_reg + 3'd1;
                                gy_reg  <= gy_reg + 13'({9'd0, scale_reg});
                            end else begin
                                row_reg <= 3'd0;
                                gy_reg  <= oy_reg;
                                state_reg <= S_FONT;
                                if (col_reg != 3'd4) begin
                                    col_reg <= col_reg + 3'd1;
                                    gx_reg  <= gx_reg + 13'({9'd0, scale_reg});
                                end else begin
                                    col_reg <= 3'd0;
                                    gx_reg  <= gx_reg + 13'({9'd0, scale_reg} * 13'd2);
                                    di_reg  <= di_reg + 4'd1;
                                    if (di_reg == n_reg - 4'd1) state_reg <= S_IDLE;
                                end
                            end
                        end
                    end
                end
                S_READ: state_reg <= S_OUT;
                S_OUT: begin
                    // hold until the previous word has left
                    if (!out_valid_reg) begin
                        out_reg   <= rd_ok_reg ? rdata_reg : 8'd0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_OUT && !out_valid_reg) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result lost");
    a_clear_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> we && wdata == 8'd0) else $error("clear missed");

endmodule

// File: hdl/digit_framebuffer_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digit_framebuffer_renderer: page framebuffer with centered digit drawing
// A front queue takes command words; a back engine works on the store.
// ----------------------------------------------------------------------------
//  channel | dir | width | content
//  s_      | in  | 72    | op, pixel_x, pixel_y, pixel_on, number_value,
//          |     |       | glyph_scale, byte_index
//  m_      | out | 8     | read_data
//
//  Clear zeroes all W*pages bytes (also after reset, 1024 at defaults, while
//  the engine takes no word). Set pixel reads, modifies and writes its byte;
//  read fetches a byte and then waits for the output. Draw takes up to 10 divide
//  steps and an origin step, then per digit 5 font fetches plus an address,
//  read and write step per scaled font pixel (read-modify-write on one port).
//  Reset is synchronous, active low. A two-word queue decouples intake
//  from the engine; a held result stalls the engine, not the intake.
// ----------------------------------------------------------------------------
module digit_framebuffer_renderer import dfr_pkg::*; #(
    parameter int DISPLAY_WIDTH  = DEF_WIDTH,
    parameter int DISPLAY_HEIGHT = DEF_HEIGHT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // op[1:0] pixel_x[10:2] pixel_y[19:11] pixel_on[20] number_value[52:21]
    // glyph_scale[56:53] byte_index[66:57], zero fill to 72
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0]
    output logic [7:0]  m_tdata
);

    logic q_valid, q_ready;
    cmd_t q_cmd;

    dfr_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .q_valid, .q_ready, .q_cmd
    );

    dfr_back #(
        .DISPLAY_WIDTH(DISPLAY_WIDTH), .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
    ) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .m_tvalid, .m_tready, .m_tdata
    );

endmodule
